@@ hw/rtl/three_class_priority_queue_assert.svh @@
// Assertion macros for the three-class priority queue.
// Each macro expands to one labeled concurrent assertion on the rising
// edge of clock, disabled while reset is high.
`ifndef THREE_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`define THREE_CLASS_PRIORITY_QUEUE_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define TCPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define TCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tcpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpq_pkg
// Types and constants shared by the three-class priority queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcpq_pkg;

   localparam int CAPACITY = 64;
   localparam int TAG_BITS = 16;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] CLS_LOW  = 2'd0;
   localparam logic [1:0] CLS_NORM = 2'd1;
   localparam logic [1:0] CLS_HIGH = 2'd2;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_TAKE  = 2'd1,
      CMD_ACCEL = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // one command as seen by the list controller
   typedef struct packed {
      logic       issue;   // beat accepted: launch memory reads
      logic       commit;  // read data back: update lists
      cmd_type    cmd;
      logic [1:0] cls;     // already saturated to high
   } op_type;

   typedef struct packed {
      logic              re;
      logic [ADDR_W-1:0] raddr;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] wdata;
   } link_req_type;

   typedef struct packed {
      status_type       status;
      logic [1:0]       prio;
      logic             take_ok;
      logic [CNT_W-1:0] total;
   } result_type;

endpackage

@@ hw/rtl/tcpq_ram.sv @@
// ----------------------------------------------------------------------------
// tcpq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/tcpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcpq_ctrl
// List bookkeeping: class heads, tails and counts, free chain head, and the
// link store addressing. Reads are launched on issue, lists updated on commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpq_ctrl
   import tcpq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  op_type             op,
   output link_req_type       link_req,
   input  logic [ADDR_W-1:0]  link_rdata,
   output logic               tag_we,
   output logic [ADDR_W-1:0]  tag_waddr,
   output result_type         result
);

   logic [ADDR_W-1:0] head_ff  [3];
   logic [ADDR_W-1:0] head_in  [3];
   logic [ADDR_W-1:0] tail_ff  [3];
   logic [ADDR_W-1:0] tail_in  [3];
   logic [CNT_W-1:0]  count_ff [3];
   logic [CNT_W-1:0]  count_in [3];
   logic [ADDR_W-1:0] free_ff;
   logic [ADDR_W-1:0] free_in;

   // link entries not yet written hold the initial free chain
   logic [CAPACITY-1:0] lvld_ff;
   logic                rd_vld_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic [ADDR_W-1:0]   link_q;

   logic [1:0]        top_cls;
   logic              any_held;
   logic [CNT_W-1:0]  total_now;
   logic              full;

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] a);
      return (a == ADDR_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
   endfunction

   assign total_now = count_ff[0] + count_ff[1] + count_ff[2];
   assign full      = (total_now >= CNT_W'(CAPACITY));
   assign any_held  = (total_now != '0);

   always_comb begin
      priority if (count_ff[CLS_HIGH] != '0) begin
         top_cls = CLS_HIGH;
      end else if (count_ff[CLS_NORM] != '0) begin
         top_cls = CLS_NORM;
      end else begin
         top_cls = CLS_LOW;
      end
   end

   assign link_q = rd_vld_ff ? link_rdata : next_slot(rd_addr_ff);

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      free_in         = free_ff;
      link_req.re     = op.issue;
      link_req.raddr  = (op.cmd == CMD_PUT) ? free_ff : head_ff[top_cls];
      link_req.we     = 1'b0;
      link_req.waddr  = '0;
      link_req.wdata  = '0;
      tag_we          = 1'b0;
      tag_waddr       = free_ff;
      result.status   = STAT_OK;
      result.prio     = CLS_LOW;
      result.take_ok  = 1'b0;
      if (op.commit) begin
         unique case (op.cmd)
            CMD_PUT: begin
               if (full) begin
                  result.status = STAT_FULL;
               end else begin
                  free_in = link_q;
                  tag_we  = 1'b1;
                  if (count_ff[op.cls] == '0) begin
                     head_in[op.cls] = free_ff;
                  end else begin
                     link_req.we    = 1'b1;
                     link_req.waddr = tail_ff[op.cls];
                     link_req.wdata = free_ff;
                  end
                  tail_in[op.cls]  = free_ff;
                  count_in[op.cls] = count_ff[op.cls] + 1'b1;
               end
            end
            CMD_TAKE: begin
               if (!any_held) begin
                  result.status = STAT_EMPTY;
               end else begin
                  result.prio       = top_cls;
                  result.take_ok    = 1'b1;
                  head_in[top_cls]  = link_q;
                  count_in[top_cls] = count_ff[top_cls] - 1'b1;
                  link_req.we       = 1'b1;
                  link_req.waddr    = head_ff[top_cls];
                  link_req.wdata    = free_ff;
                  free_in           = head_ff[top_cls];
               end
            end
            CMD_ACCEL: begin
               if (count_ff[CLS_LOW] != '0) begin
                  if (count_ff[CLS_HIGH] == '0) begin
                     head_in[CLS_HIGH] = head_ff[CLS_LOW];
                  end else begin
                     link_req.we    = 1'b1;
                     link_req.waddr = tail_ff[CLS_HIGH];
                     link_req.wdata = head_ff[CLS_LOW];
                  end
                  tail_in[CLS_HIGH]  = tail_ff[CLS_LOW];
                  count_in[CLS_HIGH] = count_ff[CLS_HIGH] + count_ff[CLS_LOW];
                  count_in[CLS_LOW]  = '0;
               end
            end
            CMD_NOP: begin
            end
            default: begin
            end
         endcase
      end
      result.total = count_in[0] + count_in[1] + count_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         free_ff <= '0;
         lvld_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         free_ff  <= free_in;
         if (link_req.we) begin
            lvld_ff[link_req.waddr] <= 1'b1;
         end
      end
   end

   // ride along with the link read so a missing entry resolves on commit
   always_ff @(posedge clock) begin
      if (op.issue) begin
         rd_vld_ff  <= lvld_ff[link_req.raddr];
         rd_addr_ff <= link_req.raddr;
      end
   end

endmodule

@@ hw/rtl/three_class_priority_queue.sv @@
// Three-class priority queue.
// Commands arrive on the req_ channel (valid/ready): put appends req_tag to
// class req_prio (code three counts as high), take removes the oldest
// element of the highest non-empty class, accelerate moves the whole low
// class behind the high class. Every command returns one beat on the rsp_
// channel with a status, the removed tag and class (zero unless a take
// succeeds) and the number of elements held afterwards.
// An accepted beat launches the link and tag store reads; the execute
// state then updates the class lists and loads the output register. One
// command is in flight at a time: a new command is not taken until the
// read of the link store has returned and the class lists are updated.
// The result sits in an output register; a new command is accepted while
// that register is empty or is being drained in the same cycle. While the
// receiver stalls, the result holds and at most one command is accepted.
// Reset (synchronous) empties all classes and rebuilds the free chain at
// once through per-entry valid bits on the link store; no clearing pass.
// ----------------------------------------------------------------------------
// three_class_priority_queue
// Top level: handshake, command capture, output register and element stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_class_priority_queue_assert.svh"

module three_class_priority_queue
   import tcpq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [1:0]          req_prio,
   input  logic [TAG_BITS-1:0] req_tag,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic [1:0]          rsp_out_prio,
   output logic [CNT_W-1:0]    rsp_total_count
);

   state_type           state_ff;
   state_type           state_in;
   cmd_type             cmd_ff;
   logic [1:0]          cls_ff;
   logic [TAG_BITS-1:0] tag_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff;
   logic [1:0]          rsp_prio_ff;
   logic [CNT_W-1:0]    rsp_total_ff;

   logic                accept;
   logic                commit;
   logic [1:0]          req_cls;
   op_type              op;
   link_req_type        link_req;
   logic [ADDR_W-1:0]   link_rdata;
   logic                tag_we;
   logic [ADDR_W-1:0]   tag_waddr;
   logic [TAG_BITS-1:0] tag_rdata;
   result_type          result;

   assign req_cls = (req_prio == 2'd3) ? CLS_HIGH : req_prio;
   assign accept  = req_valid && req_ready;

   // next state
   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            commit    = 1'b0;
         end
         S_EXEC: begin
            req_ready = 1'b0;
            commit    = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
            commit    = 1'b0;
         end
      endcase
   end

   always_comb begin
      op.issue  = accept;
      op.commit = commit;
      op.cmd    = commit ? cmd_ff : cmd_type'(req_cmd);
      op.cls    = commit ? cls_ff : req_cls;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_cmd);
         cls_ff <= req_cls;
         tag_ff <= req_tag;
      end
      if (commit) begin
         rsp_status_ff <= result.status;
         rsp_tag_ff    <= result.take_ok ? tag_rdata : '0;
         rsp_prio_ff   <= result.prio;
         rsp_total_ff  <= result.total;
      end
   end

   tcpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .link_req   (link_req),
      .link_rdata (link_rdata),
      .tag_we     (tag_we),
      .tag_waddr  (tag_waddr),
      .result     (result)
   );

   tcpq_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock (clock),
      .we    (link_req.we),
      .waddr (link_req.waddr),
      .wdata (link_req.wdata),
      .re    (link_req.re),
      .raddr (link_req.raddr),
      .rdata (link_rdata)
   );

   tcpq_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (CAPACITY)
   ) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (tag_waddr),
      .wdata (tag_ff),
      .re    (link_req.re),
      .raddr (link_req.raddr),
      .rdata (tag_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_out_prio    = rsp_prio_ff;
   assign rsp_total_count = rsp_total_ff;

   `TCPQ_ASSERT_NEXT(a_exec_after_accept, accept, (state_ff == S_EXEC) && !rsp_valid_ff, "accepted beat did not enter execute with a free output register")
   `TCPQ_ASSERT_NEXT(a_result_after_exec, state_ff == S_EXEC, rsp_valid_ff, "command finished without a result beat")
   `TCPQ_ASSERT_NOW(a_total_bound, rsp_valid_ff, rsp_total_ff <= CNT_W'(CAPACITY), "element count above capacity")
   `TCPQ_ASSERT_NOW(a_empty_means_zero, rsp_valid_ff && (rsp_status_ff == STAT_EMPTY), rsp_total_ff == '0, "empty status with elements held")

endmodule

@@ tb/three_class_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// three_class_priority_queue_tb
// Self-checking bench for the three-class priority queue. A short table of
// commands covers the empty, saturated-class and accelerate corners, then
// random segments that fill, drain or mix the queue. An in-bench model of
// the linked class lists, or the table, gives each result, all compared
// field by field in order, with random idle gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_class_priority_queue_tb;
   import tcpq_pkg::*;

   localparam int RANDOM_ITEMS = 1330;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int N_DIRECTED   = 24;
   localparam int MAX_PRINTED  = 30;

   typedef struct packed {
      status_type          status;
      logic [TAG_BITS-1:0] tag;
      logic [1:0]          prio;
      logic [CNT_W-1:0]    total;
   } queue_result_type;

   typedef struct {
      cmd_type             cmd;
      logic [1:0]          prio;
      logic [TAG_BITS-1:0] tag;
      bit                  typed;
      queue_result_type    want;
   } stim_row_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_kind_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_cmd = CMD_NOP;
   logic [1:0]          req_prio = CLS_LOW;
   logic [TAG_BITS-1:0] req_tag = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [TAG_BITS-1:0] rsp_out_tag;
   logic [1:0]          rsp_out_prio;
   logic [CNT_W-1:0]    rsp_total_count;

   // travels with the beat on the request side
   bit                  row_typed = 1'b0;
   queue_result_type    row_want = '0;

   bit                  sender_steady = 1'b0;
   bit                  receiver_steady = 1'b0;
   int                  stall_left = 0;

   queue_result_type    awaited_results[$];
   stim_row_type        directed_rows [N_DIRECTED];
   int                  mismatches = 0;
   int                  checked_results = 0;
   int                  n_puts = 0, n_drops = 0, n_takes = 0, n_empty = 0;
   int                  n_accel = 0, n_nops = 0, peak_held = 0;

   // queue model state
   logic [TAG_BITS-1:0] tag_mem [CAPACITY];
   logic [ADDR_W-1:0]   link_mem [CAPACITY];
   logic [ADDR_W-1:0]   class_head [3];
   logic [ADDR_W-1:0]   class_tail [3];
   int                  class_count [3];
   logic [ADDR_W-1:0]   free_slot;

   three_class_priority_queue DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_prio        (req_prio),
      .req_tag         (req_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_out_prio    (rsp_out_prio),
      .rsp_total_count (rsp_total_count)
   );

   always #1 clock = ~clock;

   function automatic int held_count();
      return class_count[0] + class_count[1] + class_count[2];
   endfunction

   // Applies one command to the list model and returns its result.
   function automatic queue_result_type predict_queue_result(cmd_type cmd, logic [1:0] prio,
                                                             logic [TAG_BITS-1:0] tag);
      queue_result_type  r;
      logic [1:0]        cls;
      logic [ADDR_W-1:0] slot;
      int                found;
      r = '0;
      r.status = STAT_OK;
      cls = (prio > CLS_HIGH) ? CLS_HIGH : prio;
      case (cmd)
         CMD_PUT: begin
            if (held_count() >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               slot = free_slot;
               free_slot = link_mem[slot];
               tag_mem[slot] = tag;
               if (class_count[cls] == 0) class_head[cls] = slot;
               else link_mem[class_tail[cls]] = slot;
               class_tail[cls] = slot;
               class_count[cls]++;
            end
         end
         CMD_TAKE: begin
            found = -1;
            for (int c = 2; c >= 0; c--)
               if (found < 0 && class_count[c] != 0) found = c;
            if (found < 0) begin
               r.status = STAT_EMPTY;
            end else begin
               slot = class_head[found];
               r.tag = tag_mem[slot];
               r.prio = 2'(found);
               class_head[found] = link_mem[slot];
               class_count[found]--;
               link_mem[slot] = free_slot;
               free_slot = slot;
            end
         end
         CMD_ACCEL: begin
            // low chain is spliced whole behind the high tail
            if (class_count[CLS_LOW] != 0) begin
               if (class_count[CLS_HIGH] == 0) class_head[CLS_HIGH] = class_head[CLS_LOW];
               else link_mem[class_tail[CLS_HIGH]] = class_head[CLS_LOW];
               class_tail[CLS_HIGH] = class_tail[CLS_LOW];
               class_count[CLS_HIGH] += class_count[CLS_LOW];
               class_count[CLS_LOW] = 0;
            end
         end
         default: ;
      endcase
      r.total = CNT_W'(held_count());
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want_v);
      if (mismatches < MAX_PRINTED)
         $display("tb: result %0d: %s got 0x%0h expected 0x%0h",
                  checked_results, what, got, want_v);
      mismatches++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return $urandom_range(1, 2);
      if (roll < 90) return $urandom_range(3, 6);
      return $urandom_range(7, 30);
   endfunction

   task automatic send_command(cmd_type cmd, logic [1:0] prio, logic [TAG_BITS-1:0] tag,
                               bit typed, queue_result_type want);
      int gap;
      gap = (!sender_steady && $urandom_range(0, 99) < 40) ? gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_prio  <= prio;
      req_tag   <= tag;
      row_typed <= typed;
      row_want  <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!receiver_steady && $urandom_range(0, 99) < 25) stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin : monitor
      queue_result_type want, pred;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("beat with nothing awaited, status", rsp_status, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_out_tag !== want.tag)
                  report_mismatch("out_tag", rsp_out_tag, want.tag);
               if (rsp_out_prio !== want.prio)
                  report_mismatch("out_prio", rsp_out_prio, want.prio);
               if (rsp_total_count !== want.total)
                  report_mismatch("total_count", rsp_total_count, want.total);
            end
            checked_results++;
         end
         if (req_valid && req_ready) begin
            pred = predict_queue_result(cmd_type'(req_cmd), req_prio, req_tag);
            awaited_results.push_back(row_typed ? row_want : pred);
            case (cmd_type'(req_cmd))
               CMD_PUT: begin
                  n_puts++;
                  if (pred.status == STAT_FULL) n_drops++;
               end
               CMD_TAKE: begin
                  n_takes++;
                  if (pred.status == STAT_EMPTY) n_empty++;
               end
               CMD_ACCEL: n_accel++;
               default:   n_nops++;
            endcase
            if (held_count() > peak_held) peak_held = held_count();
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("tb: no beat for %0d cycles, %0d results awaited",
               STALL_LIMIT, awaited_results.size());
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      mix_kind_type        mix;
      cmd_type             cmd;
      logic [1:0]          prio;
      logic [TAG_BITS-1:0] tag;
      int                  seg_len, roll, random_left, seg;

      for (int i = 0; i < CAPACITY; i++) begin
         tag_mem[i] = '0;
         link_mem[i] = ADDR_W'((i + 1) % CAPACITY);
      end
      for (int i = 0; i < 3; i++) begin
         class_head[i] = '0;
         class_tail[i] = '0;
         class_count[i] = 0;
      end
      free_slot = '0;

      directed_rows = '{
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b1, '{STAT_EMPTY, 16'h0000, CLS_LOW, 7'd0}},
         '{CMD_ACCEL, CLS_LOW,  16'h0000, 1'b1, '{STAT_OK,    16'h0000, CLS_LOW, 7'd0}},
         '{CMD_NOP,   CLS_LOW,  16'h0000, 1'b1, '{STAT_OK,    16'h0000, CLS_LOW, 7'd0}},
         '{CMD_PUT,   CLS_LOW,  16'hFFFF, 1'b1, '{STAT_OK,    16'h0000, CLS_LOW, 7'd1}},
         '{CMD_PUT,   2'd3,     16'h0000, 1'b1, '{STAT_OK,    16'h0000, CLS_LOW, 7'd2}},
         '{CMD_PUT,   CLS_NORM, 16'hA5A5, 1'b1, '{STAT_OK,    16'h0000, CLS_LOW, 7'd3}},
         '{CMD_PUT,   CLS_LOW,  16'h1234, 1'b1, '{STAT_OK,    16'h0000, CLS_LOW, 7'd4}},
         '{CMD_PUT,   CLS_HIGH, 16'h5A5A, 1'b1, '{STAT_OK,    16'h0000, CLS_LOW, 7'd5}},
         '{CMD_ACCEL, CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_PUT,   CLS_NORM, 16'h8001, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b1, '{STAT_EMPTY, 16'h0000, CLS_LOW, 7'd0}},
         // accelerate into an empty high class
         '{CMD_PUT,   CLS_LOW,  16'h7FFF, 1'b0, '0},
         '{CMD_ACCEL, CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_PUT,   CLS_HIGH, 16'h0001, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b0, '0},
         // unused code with junk fields must leave the lists alone
         '{CMD_NOP,   2'd3,     16'hFFFF, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b0, '0},
         '{CMD_TAKE,  CLS_LOW,  16'h0000, 1'b1, '{STAT_EMPTY, 16'h0000, CLS_LOW, 7'd0}}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].prio, directed_rows[i].tag,
                      directed_rows[i].typed, directed_rows[i].want);

      // random segments; the first one fills past capacity
      random_left = RANDOM_ITEMS;
      seg = 0;
      while (random_left > 0) begin
         mix = (seg == 0) ? MIX_FILL : mix_kind_type'($urandom_range(0, 2));
         seg_len = (seg == 0) ? 100 : $urandom_range(16, 120);
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady <= ($urandom_range(0, 3) == 0);
         for (int k = 0; k < seg_len && random_left > 0; k++) begin
            roll = $urandom_range(0, 99);
            case (mix)
               MIX_FILL:  cmd = (roll < 85) ? CMD_PUT : (roll < 95) ? CMD_TAKE :
                                (roll < 98) ? CMD_ACCEL : CMD_NOP;
               MIX_DRAIN: cmd = (roll < 15) ? CMD_PUT : (roll < 90) ? CMD_TAKE :
                                (roll < 97) ? CMD_ACCEL : CMD_NOP;
               default:   cmd = (roll < 45) ? CMD_PUT : (roll < 85) ? CMD_TAKE :
                                (roll < 96) ? CMD_ACCEL : CMD_NOP;
            endcase
            prio = 2'($urandom_range(0, 3));
            roll = $urandom_range(0, 9);
            tag = (roll == 0) ? '0 : (roll == 1) ? '1 : TAG_BITS'($urandom);
            send_command(cmd, prio, tag, 1'b0, '0);
            random_left--;
         end
         seg++;
      end
      req_valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         report_mismatch("results left awaited", awaited_results.size(), 0);

      $display("tb: %0d commands, %0d results checked, peak occupancy %0d of %0d",
               n_puts + n_takes + n_accel + n_nops, checked_results, peak_held, CAPACITY);
      $display("tb: puts %0d (dropped full %0d), takes %0d (empty %0d), accel %0d, unused %0d",
               n_puts, n_drops, n_takes, n_empty, n_accel, n_nops);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
